### hw/rtl/bezier_equal_spacing_resampler_defines.svh
// ----------------------------------------------------------------------------
// Bezier resampler assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BEZIER_EQUAL_SPACING_RESAMPLER_DEFINES_SVH
`define BEZIER_EQUAL_SPACING_RESAMPLER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define BESR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BESR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/besr_pkg.sv
// ----------------------------------------------------------------------------
// Bezier resampler package
// Shared constants and the request type of the shared multiplier unit.
// ----------------------------------------------------------------------------
package besr_pkg;

    localparam int SAMPLES_DEF = 100;
    localparam int MAX_POINTS  = 64;
    localparam int TFRAC       = 24;
    localparam int ARC_W       = 48;
    localparam int CHORD_W     = 34;

    typedef struct packed {
        logic               square;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [TFRAC-1:0]   t;
        logic [30:0]        sq;
    } mac_req_t;

endpackage

### hw/rtl/besr_mac.sv
// ----------------------------------------------------------------------------
// Bezier resampler shared multiplier
// One signed multiplier that serves either a rounded Q0.24 lerp or a square.
// ----------------------------------------------------------------------------
module besr_mac
(
    input  besr_pkg::mac_req_t req,
    output logic signed [31:0] lerp,
    output logic [61:0]        sq_prod
);

    logic signed [32:0] m1;
    logic signed [32:0] m2;
    logic signed [65:0] prod;
    logic signed [65:0] rnd;

    always_comb
    begin
        if (req.square)
        begin
            m1 = $signed({2'b00, req.sq});
            m2 = $signed({2'b00, req.sq});
        end
        else
        begin
            m1 = $signed({req.b[31], req.b}) - $signed({req.a[31], req.a});
            m2 = $signed({9'b0, req.t});
        end
        prod    = m1 * m2;
        // round half up, then floor by the arithmetic shift
        rnd     = prod + 66'sd8388608;
        lerp    = req.a + $signed(rnd[55:24]);
        sq_prod = prod[61:0];
    end

endmodule

### hw/rtl/bezier_equal_spacing_resampler.sv
// Each segment runs the curve lerps on the shared multiplier, the chord
// steps and a bit-serial square root; each emitted point adds a shift-add
// multiply, a restoring divide and a curve evaluation.
// Throughput: one request at a time; in_stall stays high until done.
// Reset clears the sequencer and the output valid; no clearing pass.
`include "bezier_equal_spacing_resampler_defines.svh"
// ----------------------------------------------------------------------------
// Bezier equal-spacing resampler
// Walks a cubic curve in SAMPLES-1 steps, sums chord lengths and emits a point
// every spacing of arc length, up to 64 points.
// ----------------------------------------------------------------------------
module bezier_equal_spacing_resampler
#(
    parameter int SAMPLES = besr_pkg::SAMPLES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] p0_x,
    input  logic signed [31:0] p0_y,
    input  logic signed [31:0] p1_x,
    input  logic signed [31:0] p1_y,
    input  logic signed [31:0] p2_x,
    input  logic signed [31:0] p2_y,
    input  logic signed [31:0] p3_x,
    input  logic signed [31:0] p3_y,
    input  logic [31:0]        spacing,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic               last,
    output logic               truncated
);

    localparam int IW = $clog2(SAMPLES);
    localparam int RW = $clog2(SAMPLES) + 1;
    localparam int TW = besr_pkg::TFRAC;
    localparam int AW = besr_pkg::ARC_W;
    localparam int CW = besr_pkg::CHORD_W;
    localparam longint TSTEP = (64'd1 << TW) / SAMPLES;
    localparam longint TREM  = (64'd1 << TW) % SAMPLES;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_EVAL   = 4'd1;
    localparam logic [3:0] ST_DIFF   = 4'd2;
    localparam logic [3:0] ST_SQX    = 4'd3;
    localparam logic [3:0] ST_SQY    = 4'd4;
    localparam logic [3:0] ST_SQRT   = 4'd5;
    localparam logic [3:0] ST_ACC    = 4'd6;
    localparam logic [3:0] ST_SCAN   = 4'd7;
    localparam logic [3:0] ST_MUL    = 4'd8;
    localparam logic [3:0] ST_DIV    = 4'd9;
    localparam logic [3:0] ST_EMIT   = 4'd10;
    localparam logic [3:0] ST_FINISH = 4'd11;

    logic [3:0]         state_reg;
    logic [3:0]         state_next;
    logic [4:0]         step_reg;
    logic               mode_pt_reg;
    logic signed [31:0] px_reg [4];
    logic signed [31:0] py_reg [4];
    logic [31:0]        spacing_reg;
    logic signed [31:0] lx_reg [3];
    logic signed [31:0] ly_reg [3];
    logic signed [31:0] ox_reg;
    logic signed [31:0] oy_reg;
    logic signed [31:0] prevx_reg;
    logic signed [31:0] prevy_reg;
    logic [IW-1:0]      i_reg;
    logic [TW-1:0]      ti_reg;
    logic [TW-1:0]      tp_reg;
    logic [TW-1:0]      teval_reg;
    logic [RW-1:0]      trem_reg;
    logic [30:0]        absx_reg;
    logic [30:0]        absy_reg;
    logic               sh_reg;
    logic [62:0]        sum_reg;
    logic [62:0]        v_reg;
    logic [62:0]        res_reg;
    logic [62:0]        bit_reg;
    logic [CW-1:0]      chord_reg;
    logic [AW-1:0]      arc_prev_reg;
    logic [AW-1:0]      arc_cur_reg;
    logic [AW-1:0]      target_reg;
    logic [TW-1:0]      dt_reg;
    logic [CW-1:0]      exc_reg;
    logic [57:0]        acc_reg;
    logic [CW:0]        rem_reg;
    logic [TW-1:0]      nlo_reg;
    logic signed [31:0] pendx_reg;
    logic signed [31:0] pendy_reg;
    logic [6:0]         cnt_reg;
    logic               trunc_reg;
    logic               out_valid_reg;
    logic signed [31:0] outx_reg;
    logic signed [31:0] outy_reg;
    logic               last_reg;
    logic               trunc_out_reg;

    besr_pkg::mac_req_t mreq;
    logic signed [31:0] lerp;
    logic [61:0]        sq_prod;
    logic [3:0]         pair;
    logic signed [31:0] eax;
    logic signed [31:0] ebx;
    logic signed [31:0] eay;
    logic signed [31:0] eby;
    logic               in_fire;
    logic               slot_free;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]        adx;
    logic [32:0]        ady;
    logic               huge;
    logic [62:0]        trial;
    logic               sq_ge;
    logic [CW:0]        dtmp;
    logic               d_ge;
    logic [TW-1:0]      q_next;
    logic [RW-1:0]      rsum;
    logic               tcarry;
    logic [TW-1:0]      ti_adv;
    logic [AW-1:0]      chord_ext;
    logic               gt;
    logic [AW-1:0]      diffe;
    logic [CW-1:0]      exc;
    logic [CW-1:0]      chord_val;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign point_x   = outx_reg;
    assign point_y   = outy_reg;
    assign last      = last_reg;
    assign truncated = trunc_out_reg;

    // de Casteljau operand select: pairs 0..2 from control points, then levels
    assign pair = {1'b0, step_reg[3:1]};

    always_comb
    begin
        unique case (pair)
            4'd0:
            begin
                eax = px_reg[0]; ebx = px_reg[1]; eay = py_reg[0]; eby = py_reg[1];
            end
            4'd1:
            begin
                eax = px_reg[1]; ebx = px_reg[2]; eay = py_reg[1]; eby = py_reg[2];
            end
            4'd2:
            begin
                eax = px_reg[2]; ebx = px_reg[3]; eay = py_reg[2]; eby = py_reg[3];
            end
            4'd3, 4'd5:
            begin
                eax = lx_reg[0]; ebx = lx_reg[1]; eay = ly_reg[0]; eby = ly_reg[1];
            end
            4'd4:
            begin
                eax = lx_reg[1]; ebx = lx_reg[2]; eay = ly_reg[1]; eby = ly_reg[2];
            end
            default:
            begin
                eax = lx_reg[0]; ebx = lx_reg[1]; eay = ly_reg[0]; eby = ly_reg[1];
            end
        endcase
        mreq.square = (state_reg == ST_SQX) || (state_reg == ST_SQY);
        mreq.a      = step_reg[0] ? eay : eax;
        mreq.b      = step_reg[0] ? eby : ebx;
        mreq.t      = teval_reg;
        mreq.sq     = (state_reg == ST_SQY) ? absy_reg : absx_reg;
    end

    besr_mac u_mac
    (
        .req     (mreq),
        .lerp    (lerp),
        .sq_prod (sq_prod)
    );

    always_comb
    begin
        dx   = $signed({ox_reg[31], ox_reg}) - $signed({prevx_reg[31], prevx_reg});
        dy   = $signed({oy_reg[31], oy_reg}) - $signed({prevy_reg[31], prevy_reg});
        adx  = dx[32] ? 33'(-dx) : 33'(dx);
        ady  = dy[32] ? 33'(-dy) : 33'(dy);
        huge = adx[32] | adx[31] | ady[32] | ady[31];

        trial = res_reg + bit_reg;
        sq_ge = (v_reg >= trial);

        dtmp   = {rem_reg[CW-1:0], nlo_reg[TW-1]};
        d_ge   = (dtmp >= {1'b0, chord_reg});
        q_next = {nlo_reg[TW-2:0], d_ge};

        rsum   = trem_reg + RW'(TREM);
        tcarry = (rsum >= RW'(SAMPLES));
        ti_adv = ti_reg + TW'(TSTEP) + TW'(tcarry);

        chord_val = sh_reg ? {res_reg[CW-2:0], 1'b0} : res_reg[CW-1:0];
        chord_ext = AW'(chord_reg);
        gt        = (arc_cur_reg > target_reg);
        diffe     = arc_cur_reg - target_reg;
        exc       = (diffe > chord_ext) ? chord_reg : diffe[CW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_fire) state_next = ST_EVAL;
            ST_EVAL:   if (step_reg == 5'd11) state_next = mode_pt_reg ? ST_EMIT : ST_DIFF;
            ST_DIFF:   state_next = ST_SQX;
            ST_SQX:    state_next = ST_SQY;
            ST_SQY:    state_next = ST_SQRT;
            ST_SQRT:   if (step_reg == 5'd31) state_next = ST_ACC;
            ST_ACC:    state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (gt && (chord_reg != '0))
                    state_next = (cnt_reg == 7'(besr_pkg::MAX_POINTS)) ? ST_FINISH : ST_MUL;
                else if (i_reg == IW'(SAMPLES - 1))
                    state_next = ST_FINISH;
                else
                    state_next = ST_EVAL;
            end
            ST_MUL:    if (step_reg == 5'd23) state_next = ST_DIV;
            ST_DIV:    if (step_reg == 5'd23) state_next = ST_EVAL;
            ST_EMIT:   if (slot_free) state_next = ST_SCAN;
            ST_FINISH: if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_EMIT || state_reg == ST_FINISH) && slot_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (in_fire)
                cnt_reg <= 7'd1;
            else if (state_reg == ST_EMIT && slot_free)
                cnt_reg <= cnt_reg + 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_next != state_reg)
            step_reg <= '0;
        else
            step_reg <= step_reg + 5'd1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    px_reg[0]    <= p0_x; py_reg[0] <= p0_y;
                    px_reg[1]    <= p1_x; py_reg[1] <= p1_y;
                    px_reg[2]    <= p2_x; py_reg[2] <= p2_y;
                    px_reg[3]    <= p3_x; py_reg[3] <= p3_y;
                    spacing_reg  <= spacing;
                    prevx_reg    <= p0_x;
                    prevy_reg    <= p0_y;
                    pendx_reg    <= p0_x;
                    pendy_reg    <= p0_y;
                    i_reg        <= IW'(1);
                    tp_reg       <= '0;
                    ti_reg       <= TW'(TSTEP);
                    teval_reg    <= TW'(TSTEP);
                    trem_reg     <= RW'(TREM);
                    arc_prev_reg <= '0;
                    target_reg   <= AW'(spacing);
                    trunc_reg    <= 1'b0;
                    mode_pt_reg  <= 1'b0;
                end
            end
            ST_EVAL:
            begin
                if (pair == 4'd5)
                begin
                    if (step_reg[0]) oy_reg <= lerp;
                    else             ox_reg <= lerp;
                end
                else
                begin
                    if (step_reg[0])
                        ly_reg[(pair >= 4'd3) ? 2'(pair - 4'd3) : pair[1:0]] <= lerp;
                    else
                        lx_reg[(pair >= 4'd3) ? 2'(pair - 4'd3) : pair[1:0]] <= lerp;
                end
            end
            ST_DIFF:
            begin
                absx_reg <= huge ? adx[31:1] : adx[30:0];
                absy_reg <= huge ? ady[31:1] : ady[30:0];
                sh_reg   <= huge;
            end
            ST_SQX:
            begin
                sum_reg <= {1'b0, sq_prod};
            end
            ST_SQY:
            begin
                v_reg   <= sum_reg + {1'b0, sq_prod};
                res_reg <= '0;
                bit_reg <= 63'(64'd1 << 62);
            end
            ST_SQRT:
            begin
                if (sq_ge)
                begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                    res_reg <= res_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            ST_ACC:
            begin
                chord_reg   <= chord_val;
                arc_cur_reg <= arc_prev_reg + AW'(chord_val);
                prevx_reg   <= ox_reg;
                prevy_reg   <= oy_reg;
            end
            ST_SCAN:
            begin
                if (gt && (chord_reg != '0))
                begin
                    if (cnt_reg == 7'(besr_pkg::MAX_POINTS))
                        trunc_reg <= 1'b1;
                    exc_reg <= exc;
                    dt_reg  <= ti_reg - tp_reg;
                    acc_reg <= '0;
                end
                else
                begin
                    // advance to the next segment
                    arc_prev_reg <= arc_cur_reg;
                    i_reg        <= i_reg + IW'(1);
                    tp_reg       <= ti_reg;
                    ti_reg       <= ti_adv;
                    teval_reg    <= ti_adv;
                    trem_reg     <= tcarry ? RW'(rsum - RW'(SAMPLES)) : rsum;
                    mode_pt_reg  <= 1'b0;
                end
            end
            ST_MUL:
            begin
                acc_reg <= (acc_reg << 1) + (dt_reg[TW-1] ? 58'(exc_reg) : 58'd0);
                dt_reg  <= dt_reg << 1;
                if (step_reg == 5'd23)
                begin
                    rem_reg <= '0;
                    nlo_reg <= '0;
                end
            end
            ST_DIV:
            begin
                if (step_reg == 5'd0)
                begin
                    // first quotient bit from the finished product
                    if ({acc_reg[57:23]} >= {1'b0, chord_reg})
                    begin
                        rem_reg <= acc_reg[57:23] - {1'b0, chord_reg};
                        nlo_reg <= {acc_reg[22:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= acc_reg[57:23];
                        nlo_reg <= {acc_reg[22:0], 1'b0};
                    end
                end
                else
                begin
                    rem_reg <= d_ge ? (dtmp - {1'b0, chord_reg}) : dtmp;
                    nlo_reg <= q_next;
                    if (step_reg == 5'd23)
                    begin
                        teval_reg   <= ti_reg - q_next;
                        mode_pt_reg <= 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    outx_reg      <= pendx_reg;
                    outy_reg      <= pendy_reg;
                    last_reg      <= 1'b0;
                    trunc_out_reg <= 1'b0;
                    pendx_reg     <= ox_reg;
                    pendy_reg     <= oy_reg;
                    target_reg    <= target_reg + AW'(spacing_reg);
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    outx_reg      <= pendx_reg;
                    outy_reg      <= pendy_reg;
                    last_reg      <= 1'b1;
                    trunc_out_reg <= trunc_reg;
                end
            end
            default:
            begin
                mode_pt_reg <= 1'b0;
            end
        endcase
    end

    `BESR_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_reg <= 7'(besr_pkg::MAX_POINTS), "point count over cap")
    `BESR_ASSERT_IMP(a_trunc_last, out_valid_reg && trunc_out_reg, last_reg, "truncated beat without last")
    `BESR_ASSERT_NXT(a_finish, (state_reg == ST_FINISH) && slot_free, (state_reg == ST_IDLE) && out_valid_reg && last_reg, "final beat not presented")

endmodule

### tb/tb_bezier_equal_spacing_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier equal-spacing resampler testbench
// Sends control-point requests in bursts, stalls the point stream on a
// changing pattern and checks every emitted point against a fixed-point
// predictor of the curve walk kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_bezier_equal_spacing_resampler;

    localparam int NSTEP     = besr_pkg::SAMPLES_DEF;
    localparam int POINT_CAP = besr_pkg::MAX_POINTS;
    localparam int TF        = besr_pkg::TFRAC;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        bit                 last;
        bit                 trunc;
    } curve_point_t;

    typedef struct {
        logic signed [31:0] px[4];
        logic signed [31:0] py[4];
        logic [31:0]        sp;
    } curve_req_t;

    class ResampleBoard;
        curve_point_t pending_pts[$];
        int           errors = 0;

        function automatic longint lerp_fix(longint a, longint b, longint unsigned t);
            longint p;
            p = (b - a) * longint'(t);
            return a + ((p + (longint'(1) << (TF - 1))) >>> TF);
        endfunction

        function automatic void curve_at(curve_req_t r, longint unsigned t,
                                         output longint ox, output longint oy);
            longint ax, ay, bx, by, cx, cy, dx, dy, ex, ey;
            ax = lerp_fix(r.px[0], r.px[1], t); ay = lerp_fix(r.py[0], r.py[1], t);
            bx = lerp_fix(r.px[1], r.px[2], t); by = lerp_fix(r.py[1], r.py[2], t);
            cx = lerp_fix(r.px[2], r.px[3], t); cy = lerp_fix(r.py[2], r.py[3], t);
            dx = lerp_fix(ax, bx, t); dy = lerp_fix(ay, by, t);
            ex = lerp_fix(bx, cx, t); ey = lerp_fix(by, cy, t);
            ox = lerp_fix(dx, ex, t);
            oy = lerp_fix(dy, ey, t);
        endfunction

        function automatic longint unsigned root_floor(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v -= res + b;
                    res = (res >> 1) + b;
                end
                else
                begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function automatic longint unsigned chord_len(longint x0, longint y0,
                                                      longint x1, longint y1);
            longint          dx, dy;
            longint unsigned ax, ay;
            int              sh;
            dx = x1 - x0;
            dy = y1 - y0;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            sh = 0;
            // halve huge deltas so the squares stay in 64 bits
            if (((ax | ay) >> 31) != 0)
            begin
                ax >>= 1;
                ay >>= 1;
                sh = 1;
            end
            return root_floor(ax * ax + ay * ay) << sh;
        endfunction

        function automatic longint unsigned t_step(int i);
            return (longint'(i) << TF) / NSTEP;
        endfunction

        // Walk the curve and queue every point this request should emit.
        function automatic void note_request(curve_req_t r);
            longint unsigned arc[NSTEP];
            longint unsigned target, seg, excess, ti, tp;
            longint          prevx, prevy, cx, cy;
            curve_point_t    pts[$];
            curve_point_t    pt;
            bit              trunc;
            arc[0] = 0;
            prevx = r.px[0];
            prevy = r.py[0];
            for (int i = 1; i < NSTEP; i++)
            begin
                curve_at(r, t_step(i), cx, cy);
                arc[i] = arc[i-1] + chord_len(prevx, prevy, cx, cy);
                prevx = cx;
                prevy = cy;
            end
            pt = '{r.px[0], r.py[0], 1'b0, 1'b0};
            pts.push_back(pt);
            target = r.sp;
            trunc = 0;
            for (int i = 1; i < NSTEP && !trunc; i++)
            begin
                while (arc[i] > target)
                begin
                    seg = arc[i] - arc[i-1];
                    if (seg == 0) break;
                    if (pts.size() >= POINT_CAP)
                    begin
                        trunc = 1;
                        break;
                    end
                    excess = arc[i] - target;
                    if (excess > seg) excess = seg;
                    ti = t_step(i);
                    tp = t_step(i - 1);
                    curve_at(r, ti - ((ti - tp) * excess) / seg, cx, cy);
                    pt = '{cx[31:0], cy[31:0], 1'b0, 1'b0};
                    pts.push_back(pt);
                    target += r.sp;
                end
            end
            pts[pts.size()-1].last = 1;
            pts[pts.size()-1].trunc = trunc;
            foreach (pts[k]) pending_pts.push_back(pts[k]);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
            errors++;
        endtask

        task check_point(curve_point_t got);
            curve_point_t want;
            if (pending_pts.size() == 0)
            begin
                $display("%0t: unexpected point %h,%h", $realtime, got.x, got.y);
                errors++;
                return;
            end
            want = pending_pts.pop_front();
            if (got.x !== want.x) report_mismatch("point_x", got.x, want.x);
            if (got.y !== want.y) report_mismatch("point_y", got.y, want.y);
            if (got.last !== want.last) report_mismatch("last", got.last, want.last);
            if (got.trunc !== want.trunc) report_mismatch("truncated", got.trunc, want.trunc);
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
    logic [31:0]        spacing;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] point_x, point_y;
    logic               last, truncated;

    ResampleBoard board;
    int           stall_mode;
    int           burst_left;

    bezier_equal_spacing_resampler dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .p0_x(p0_x), .p0_y(p0_y), .p1_x(p1_x), .p1_y(p1_y),
        .p2_x(p2_x), .p2_y(p2_y), .p3_x(p3_x), .p3_y(p3_y),
        .spacing(spacing),
        .out_valid(out_valid), .out_stall(out_stall),
        .point_x(point_x), .point_y(point_y),
        .last(last), .truncated(truncated)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver stall pattern: switch mode now and then.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ($urandom_range(0, 99) < 80);
            default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        curve_point_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{point_x, point_y, last, truncated};
            board.check_point(got);
        end
    end

    // Hold the beat until accepted; open gaps between bursts.
    task send_curve(curve_req_t r);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(0, 30)) @(negedge clk);
            burst_left = $urandom_range(1, 5);
        end
        {p0_x, p1_x, p2_x, p3_x} = {r.px[0], r.px[1], r.px[2], r.px[3]};
        {p0_y, p1_y, p2_y, p3_y} = {r.py[0], r.py[1], r.py[2], r.py[3]};
        spacing = r.sp;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        board.note_request(r);
        burst_left--;
        @(negedge clk);
        if (burst_left == 0) in_valid = 1'b0;
    endtask

    task send_pts(logic signed [31:0] x0, logic signed [31:0] y0,
                  logic signed [31:0] x1, logic signed [31:0] y1,
                  logic signed [31:0] x2, logic signed [31:0] y2,
                  logic signed [31:0] x3, logic signed [31:0] y3,
                  logic [31:0] sp);
        curve_req_t r;
        r.px = '{x0, x1, x2, x3};
        r.py = '{y0, y1, y2, y3};
        r.sp = sp;
        send_curve(r);
    endtask

    // Drop valid and end the burst, then wait for every expected point.
    task drain;
        in_valid = 1'b0;
        burst_left = 0;
        while (board.pending_pts.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] coord(logic signed [31:0] base, int bits);
        logic signed [31:0] v;
        v = $urandom;
        return base + (v >>> (32 - bits));
    endfunction

    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;

    initial
    begin
        curve_req_t         r;
        int                 bits;
        logic signed [31:0] base_x, base_y;
        board = new();
        burst_left = 0;
        rst_n = 0;
        in_valid = 0;
        {p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y} = '0;
        spacing = 0;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // degenerate curve: every segment has zero length
        send_pts(0, 0, 0, 0, 0, 0, 0, 0, 1);
        send_pts(0, 0, 33*ONE, 0, 66*ONE, 0, 100*ONE, 0, 10*ONE);
        send_pts(0, 0, 33*ONE, 0, 66*ONE, 0, 100*ONE, 0, 7*ONE + 12345);
        send_pts(MINV, MINV, MINV, MAXV, MAXV, MINV, MAXV, MAXV, 32'hffff_ffff);
        send_pts(MINV, MINV, MINV, MAXV, MAXV, MINV, MAXV, MAXV, ONE);
        send_pts(MINV, 0, MAXV, 0, MINV, 0, MAXV, 0, 32'h8000_0000);
        send_pts(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 5);
        send_pts(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, 32'hffff_ffff);
        // point cap with a tiny spacing
        send_pts(0, 0, 5*ONE, 9*ONE, -4*ONE, 7*ONE, 3*ONE, -2*ONE, 1);
        send_pts(0, 0, 5*ONE, 9*ONE, -4*ONE, 7*ONE, 3*ONE, -2*ONE, 32'hffff_ffff);
        // tiny curve: most chords round to zero
        send_pts(ONE, ONE, ONE, ONE, ONE, ONE, ONE + 3, ONE, 1);
        send_pts(-ONE, 2, -ONE, 2, -ONE, 2, -ONE + 60, 2, 2);
        // loop with a cusp
        send_pts(0, 0, 20*ONE, 20*ONE, -20*ONE, 20*ONE, 0, 0, 3*ONE);
        send_pts(32'shaaaa_aaaa, 32'sh5555_5555, 32'sh5555_5555, 32'shaaaa_aaaa,
                 32'shaaaa_aaaa, 32'sh5555_5555, 32'sh5555_5555, 32'shaaaa_aaaa,
                 32'h5555_5555);
        send_pts(-7*ONE, 3*ONE, 40*ONE, -12*ONE, 1*ONE, 50*ONE, 25*ONE, 25*ONE, 2*ONE);
        drain();

        for (int n = 0; n < 135; n++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // raw beat: every bit free
                foreach (r.px[k])
                begin
                    r.px[k] = $urandom;
                    r.py[k] = $urandom;
                end
                r.sp = $urandom;
                if (r.sp == 0) r.sp = 1;
            end
            else
            begin
                bits = $urandom_range(4, 30);
                base_x = $urandom;
                base_y = $urandom;
                base_x = base_x >>> 2;
                base_y = base_y >>> 2;
                foreach (r.px[k])
                begin
                    r.px[k] = coord(base_x, bits);
                    r.py[k] = coord(base_y, bits);
                end
                // spacing from the curve size down to a 128th of it, plus up to an eighth of it
                r.sp = (32'd1 << bits) >> $urandom_range(0, 7);
                r.sp = r.sp + ($urandom & ((32'd1 << bits) - 1)) / 8;
                if (r.sp == 0) r.sp = 1;
            end
            send_curve(r);
            if (n == 60) drain();
        end

        drain();
        repeat (200) @(posedge clk);
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
